/* src/rot3_pkg.sv */
// shared constants, axis codes and arctangent table for the axis rotation block
`timescale 1ns / 1ps

package rot3_pkg;

  // angle input and internal fixed-point formats
  localparam int ANGLE_W     = 20;  // signed Q3.16 radians
  localparam int ANGLE_SHIFT = 12;  // Q3.16 -> Q28
  localparam int THETA_W     = 33;  // Q28 angle before quadrant reduction
  localparam int CORDIC_W    = 32;  // cordic x, y, z datapath
  localparam int CORDIC_FRAC = 28;
  localparam int ATAN_DEPTH  = 24;
  localparam int ATAN_IDX_W  = 5;

  localparam longint Q28_ONE     = 64'sd268435456;
  localparam longint Q28_PI      = 64'sd843314857;
  localparam longint Q28_TWO_PI  = 64'sd1686629713;
  localparam longint Q28_HALF_PI = 64'sd421657428;
  localparam longint GAIN_INV    = 64'sd163008218;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_e;

  // atan(2^-i) in Q28
  function automatic logic signed [CORDIC_W-1:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CORDIC_W-1:0] r;
    case (idx)
      5'd0:    r = 32'sd210828714;
      5'd1:    r = 32'sd124459457;
      5'd2:    r = 32'sd65760959;
      5'd3:    r = 32'sd33381290;
      5'd4:    r = 32'sd16755422;
      5'd5:    r = 32'sd8385879;
      5'd6:    r = 32'sd4193963;
      5'd7:    r = 32'sd2097109;
      5'd8:    r = 32'sd1048571;
      5'd9:    r = 32'sd524287;
      5'd10:   r = 32'sd262144;
      5'd11:   r = 32'sd131072;
      5'd12:   r = 32'sd65536;
      5'd13:   r = 32'sd32768;
      5'd14:   r = 32'sd16384;
      5'd15:   r = 32'sd8192;
      5'd16:   r = 32'sd4096;
      5'd17:   r = 32'sd2048;
      5'd18:   r = 32'sd1024;
      5'd19:   r = 32'sd512;
      5'd20:   r = 32'sd256;
      5'd21:   r = 32'sd128;
      5'd22:   r = 32'sd64;
      5'd23:   r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/rot3_intf.sv */
// point and result channel interfaces of the axis rotation block
`timescale 1ns / 1ps

interface rot3_in_if #(
  parameter int COORD_BITS = 32
);
  logic                                  valid;
  logic                                  ready;
  logic signed [COORD_BITS-1:0]          x_in;
  logic signed [COORD_BITS-1:0]          y_in;
  logic signed [COORD_BITS-1:0]          z_in;
  logic                                  w_in;
  logic [1:0]                            axis;
  logic                                  direction;
  logic signed [rot3_pkg::ANGLE_W-1:0]   angle;

  modport source (output valid, x_in, y_in, z_in, w_in, axis, direction, angle, input ready);
  modport sink (input valid, x_in, y_in, z_in, w_in, axis, direction, angle, output ready);
endinterface

interface rot3_out_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_out;
  logic signed [COORD_BITS-1:0] y_out;
  logic signed [COORD_BITS-1:0] z_out;
  logic                         w_out;
  logic                         bad_axis;

  modport source (output valid, x_out, y_out, z_out, w_out, bad_axis, input ready);
  modport sink (input valid, x_out, y_out, z_out, w_out, bad_axis, output ready);
endinterface

/* src/rot3_angle_reduce.sv */
// two-stage angle wrap and quadrant reduction into the cordic range
`timescale 1ns / 1ps

module rot3_angle_reduce #(
  parameter int PASS_W = 100
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic signed [rot3_pkg::ANGLE_W-1:0]       angle_i,
  input  logic [PASS_W-1:0]                         pass_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output logic signed [rot3_pkg::CORDIC_W-1:0]      z_o,
  output logic                                      flip_o,
  output logic [PASS_W-1:0]                         pass_o
);

  localparam int TH_W = rot3_pkg::THETA_W;
  localparam int CW   = rot3_pkg::CORDIC_W;
  localparam int EXT  = TH_W - rot3_pkg::ANGLE_W - rot3_pkg::ANGLE_SHIFT;

  localparam logic signed [TH_W-1:0] PI       = TH_W'(rot3_pkg::Q28_PI);
  localparam logic signed [TH_W-1:0] NEG_PI   = TH_W'(-rot3_pkg::Q28_PI);
  localparam logic signed [TH_W-1:0] TWO_PI   = TH_W'(rot3_pkg::Q28_TWO_PI);
  localparam logic signed [TH_W-1:0] HALF_PI  = TH_W'(rot3_pkg::Q28_HALF_PI);
  localparam logic signed [TH_W-1:0] NEG_HALF = TH_W'(-rot3_pkg::Q28_HALF_PI);

  logic                    v1_q, v2_q;
  logic                    rdy1, rdy2;
  logic signed [TH_W-1:0]  theta, wrap_d, th1_q, quad_d;
  logic                    flip_d, flip_q;
  logic signed [CW-1:0]    z_q;
  logic [PASS_W-1:0]       p1_q, p2_q;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // stage 1: widen to q28, one wrap by two pi covers the whole input range
  always_comb begin
    theta = $signed({{EXT{angle_i[rot3_pkg::ANGLE_W-1]}}, angle_i,
                     {rot3_pkg::ANGLE_SHIFT{1'b0}}});
    if (theta > PI) begin
      wrap_d = theta - TWO_PI;
    end else if (theta < NEG_PI) begin
      wrap_d = theta + TWO_PI;
    end else begin
      wrap_d = theta;
    end
  end

  // stage 2: fold into [-pi/2, pi/2], result sign flipped later
  always_comb begin
    flip_d = 1'b0;
    quad_d = th1_q;
    if (th1_q > HALF_PI) begin
      quad_d = th1_q - PI;
      flip_d = 1'b1;
    end else if (th1_q < NEG_HALF) begin
      quad_d = th1_q + PI;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      th1_q <= wrap_d;
      p1_q  <= pass_i;
    end
    if (rdy2 && v1_q) begin
      z_q    <= CW'(quad_d);
      flip_q <= flip_d;
      p2_q   <= p1_q;
    end
  end

  assign valid_o = v2_q;
  assign z_o     = z_q;
  assign flip_o  = flip_q;
  assign pass_o  = p2_q;

endmodule

/* src/rot3_cordic_stage.sv */
// one registered rotation-mode cordic iteration
`timescale 1ns / 1ps

module rot3_cordic_stage #(
  parameter int STEP   = 0,
  parameter int PASS_W = 101
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [rot3_pkg::CORDIC_W-1:0]  x_i,
  input  logic signed [rot3_pkg::CORDIC_W-1:0]  y_i,
  input  logic signed [rot3_pkg::CORDIC_W-1:0]  z_i,
  input  logic [PASS_W-1:0]                     pass_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [rot3_pkg::CORDIC_W-1:0]  x_o,
  output logic signed [rot3_pkg::CORDIC_W-1:0]  y_o,
  output logic signed [rot3_pkg::CORDIC_W-1:0]  z_o,
  output logic [PASS_W-1:0]                     pass_o
);

  localparam int CW = rot3_pkg::CORDIC_W;
  localparam logic signed [CW-1:0] ATAN =
    rot3_pkg::atan_q28(rot3_pkg::ATAN_IDX_W'(STEP));

  logic                 v_q;
  logic signed [CW-1:0] xs, ys, x_d, y_d, z_d;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic [PASS_W-1:0]    p_q;

  assign ready_o = !v_q || ready_i;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!z_i[CW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      p_q <= pass_i;
    end
  end

  assign valid_o = v_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign pass_o  = p_q;

endmodule

/* src/rot3_apply.sv */
// trig conditioning, products, rounding and saturation of the rotated pair
`timescale 1ns / 1ps

module rot3_apply #(
  parameter int COORD_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [rot3_pkg::CORDIC_W-1:0]  cos_i,
  input  logic signed [rot3_pkg::CORDIC_W-1:0]  sin_i,
  input  logic                                  flip_i,
  input  logic signed [COORD_BITS-1:0]          x_i,
  input  logic signed [COORD_BITS-1:0]          y_i,
  input  logic signed [COORD_BITS-1:0]          z_i,
  input  logic                                  w_i,
  input  logic [1:0]                            axis_i,
  input  logic                                  dir_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [COORD_BITS-1:0]          x_o,
  output logic signed [COORD_BITS-1:0]          y_o,
  output logic signed [COORD_BITS-1:0]          z_o,
  output logic                                  w_o,
  output logic                                  bad_o
);

  localparam int CB = COORD_BITS;
  localparam int CW = rot3_pkg::CORDIC_W;
  localparam int TF = ((61 - CB) < rot3_pkg::CORDIC_FRAC) ? (61 - CB) : rot3_pkg::CORDIC_FRAC;
  localparam int SH = rot3_pkg::CORDIC_FRAC - TF;
  localparam int TW = TF + 2;
  localparam int PW = CB + TW;
  localparam int SW = PW + 2;
  localparam int RW = SW - TF;

  localparam logic signed [CW-1:0] ONE      = CW'(rot3_pkg::Q28_ONE);
  localparam logic signed [CW-1:0] NEG_ONE  = CW'(-rot3_pkg::Q28_ONE);
  localparam logic signed [CW-1:0] TRIG_RND = CW'((64'sd1 <<< SH) >>> 1);
  localparam logic signed [SW-1:0] OUT_RND  = SW'(64'sd1 <<< (TF - 1));
  localparam logic signed [RW-1:0] MAXV     = RW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] MINV     = RW'(-(64'sd1 <<< (CB - 1)));

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic                 rdy1, rdy2, rdy3, rdy4;

  // stage 1
  logic signed [CW-1:0] cf, sf, cc, sc, cr, sr;
  logic signed [TW-1:0] c_d, s_d, ns_d;
  logic signed [CB-1:0] u_d, v_d, k_d;
  logic signed [TW-1:0] c1_q, s1_q, ns1_q;
  logic signed [CB-1:0] u1_q, v1d_q, k1_q;
  logic [1:0]           ax1_q;
  logic                 w1_q;

  // stage 2
  logic signed [PW-1:0] uc_q, vns_q, us_q, vc_q;
  logic signed [CB-1:0] k2_q;
  logic [1:0]           ax2_q;
  logic                 w2_q;

  // stage 3
  logic signed [SW-1:0] su, sv;
  logic signed [RW-1:0] ru_q, rv_q;
  logic signed [CB-1:0] k3_q;
  logic [1:0]           ax3_q;
  logic                 w3_q;

  // stage 4
  logic signed [CB-1:0] ou, ov;
  logic signed [CB-1:0] x_d, y_d, z_d, x_q, y_q, z_q;
  logic                 bad_d, bad_q, w4_q;

  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // undo the quadrant fold, clamp to one, round to the trig format
  always_comb begin
    cf = flip_i ? -cos_i : cos_i;
    sf = flip_i ? -sin_i : sin_i;
    cc = (cf > ONE) ? ONE : ((cf < NEG_ONE) ? NEG_ONE : cf);
    sc = (sf > ONE) ? ONE : ((sf < NEG_ONE) ? NEG_ONE : sf);
    cr = (cc + TRIG_RND) >>> SH;
    sr = (sc + TRIG_RND) >>> SH;
    c_d = TW'(cr);
    s_d = dir_i ? -TW'(sr) : TW'(sr);
    ns_d = -s_d;
  end

  // pick the rotated pair (u, v) with u' = c*u - s*v, v' = s*u + c*v
  always_comb begin
    case (rot3_pkg::axis_e'(axis_i))
      rot3_pkg::AXIS_X: begin
        u_d = y_i;
        v_d = z_i;
        k_d = x_i;
      end
      rot3_pkg::AXIS_Y: begin
        u_d = z_i;
        v_d = x_i;
        k_d = y_i;
      end
      rot3_pkg::AXIS_Z: begin
        u_d = x_i;
        v_d = y_i;
        k_d = z_i;
      end
      default: begin
        u_d = '0;
        v_d = '0;
        k_d = '0;
      end
    endcase
  end

  always_comb begin
    su = SW'(uc_q) + SW'(vns_q) + OUT_RND;
    sv = SW'(us_q) + SW'(vc_q) + OUT_RND;
  end

  always_comb begin
    ou = (ru_q > MAXV) ? CB'(MAXV) : ((ru_q < MINV) ? CB'(MINV) : CB'(ru_q));
    ov = (rv_q > MAXV) ? CB'(MAXV) : ((rv_q < MINV) ? CB'(MINV) : CB'(rv_q));
    bad_d = 1'b0;
    case (rot3_pkg::axis_e'(ax3_q))
      rot3_pkg::AXIS_X: begin
        x_d = k3_q;
        y_d = ou;
        z_d = ov;
      end
      rot3_pkg::AXIS_Y: begin
        x_d = ov;
        y_d = k3_q;
        z_d = ou;
      end
      rot3_pkg::AXIS_Z: begin
        x_d = ou;
        y_d = ov;
        z_d = k3_q;
      end
      default: begin
        x_d   = '0;
        y_d   = '0;
        z_d   = '0;
        bad_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      c1_q  <= c_d;
      s1_q  <= s_d;
      ns1_q <= ns_d;
      u1_q  <= u_d;
      v1d_q <= v_d;
      k1_q  <= k_d;
      ax1_q <= axis_i;
      w1_q  <= w_i;
    end
    if (rdy2 && v1_q) begin
      uc_q  <= u1_q * c1_q;
      vns_q <= v1d_q * ns1_q;
      us_q  <= u1_q * s1_q;
      vc_q  <= v1d_q * c1_q;
      k2_q  <= k1_q;
      ax2_q <= ax1_q;
      w2_q  <= w1_q;
    end
    if (rdy3 && v2_q) begin
      ru_q  <= RW'(su >>> TF);
      rv_q  <= RW'(sv >>> TF);
      k3_q  <= k2_q;
      ax3_q <= ax2_q;
      w3_q  <= w2_q;
    end
    if (rdy4 && v3_q) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      bad_q <= bad_d;
      w4_q  <= w3_q;
    end
  end

  assign valid_o = v4_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign w_o     = w4_q;
  assign bad_o   = bad_q;

endmodule

/* src/axis_rotation_3d.sv */
// top level: streaming rotation of a point about the x, y or z axis
`timescale 1ns / 1ps

// Rotates one point (signed Q16.16 coordinates) about a principal axis by an
// angle in radians (signed Q3.16); direction right rotates by the negated angle,
// w passes through, and axis code 3 returns zero coordinates with bad_axis set.
// The block is a fully unrolled pipeline: two angle reduction stages, one
// register stage per cordic iteration (ROTATE_STEPS of them), then four stages
// for trig rounding, the products, the rounded sums and the saturated output
// register. It takes one point per cycle while the output is not
// stalled. Every stage has its own valid bit and moves whenever the stage after
// it is empty or moving, so a stall at the output backs up without losing or
// repeating a beat and bubbles are squeezed out. Coordinates are COORD_BITS
// wide and saturate on overflow.

module axis_rotation_3d #(
  parameter int COORD_BITS   = 32,
  parameter int ROTATE_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rot3_in_if.sink     pnt_i,
  rot3_out_if.source  pnt_o
);

  localparam int CB      = COORD_BITS;
  localparam int N       = ROTATE_STEPS;
  localparam int CW      = rot3_pkg::CORDIC_W;
  localparam int PASS_W  = 3 * CB + 4;   // x, y, z, w, axis, direction
  localparam int CPASS_W = PASS_W + 1;   // plus quadrant flip

  // point fields that ride along with the angle
  logic [PASS_W-1:0]  in_pass, red_pass;
  logic               red_valid, red_ready, red_flip;
  logic signed [CW-1:0] red_z;

  // cordic chain: index k feeds iteration k, index N is the final result
  logic signed [CW-1:0] cx [0:N];
  logic signed [CW-1:0] cy [0:N];
  logic signed [CW-1:0] cz [0:N];
  logic [CPASS_W-1:0]   cp [0:N];
  logic [N:0]           cv;
  logic [N:0]           crdy;

  // fields unpacked after the last iteration
  logic signed [CB-1:0] fx, fy, fz;
  logic                 fw, fdir, fflip;
  logic [1:0]           faxis;

  assign in_pass = {pnt_i.x_in, pnt_i.y_in, pnt_i.z_in, pnt_i.w_in, pnt_i.axis,
                    pnt_i.direction};

  rot3_angle_reduce #(
    .PASS_W (PASS_W)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pnt_i.valid),
    .ready_o (pnt_i.ready),
    .angle_i (pnt_i.angle),
    .pass_i  (in_pass),
    .valid_o (red_valid),
    .ready_i (red_ready),
    .z_o     (red_z),
    .flip_o  (red_flip),
    .pass_o  (red_pass)
  );

  // cordic seed: x starts at the inverse gain so no scaling is needed after
  assign cx[0]     = CW'(rot3_pkg::GAIN_INV);
  assign cy[0]     = '0;
  assign cz[0]     = red_z;
  assign cp[0]     = {red_flip, red_pass};
  assign cv[0]     = red_valid;
  assign red_ready = crdy[0];

  for (genvar k = 0; k < N; k++) begin : g_cordic
    rot3_cordic_stage #(
      .STEP   (k),
      .PASS_W (CPASS_W)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .ready_o (crdy[k]),
      .x_i     (cx[k]),
      .y_i     (cy[k]),
      .z_i     (cz[k]),
      .pass_i  (cp[k]),
      .valid_o (cv[k+1]),
      .ready_i (crdy[k+1]),
      .x_o     (cx[k+1]),
      .y_o     (cy[k+1]),
      .z_o     (cz[k+1]),
      .pass_o  (cp[k+1])
    );
  end

  assign {fflip, fx, fy, fz, fw, faxis, fdir} = cp[N];

  // cosine is the cordic x output, sine the y output
  rot3_apply #(
    .COORD_BITS (CB)
  ) u_apply (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv[N]),
    .ready_o (crdy[N]),
    .cos_i   (cx[N]),
    .sin_i   (cy[N]),
    .flip_i  (fflip),
    .x_i     (fx),
    .y_i     (fy),
    .z_i     (fz),
    .w_i     (fw),
    .axis_i  (faxis),
    .dir_i   (fdir),
    .valid_o (pnt_o.valid),
    .ready_i (pnt_o.ready),
    .x_o     (pnt_o.x_out),
    .y_o     (pnt_o.y_out),
    .z_o     (pnt_o.z_out),
    .w_o     (pnt_o.w_out),
    .bad_o   (pnt_o.bad_axis)
  );

  // invalid axis always carries zero coordinates
  a_bad_axis_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pnt_o.valid && pnt_o.bad_axis |->
      pnt_o.x_out == '0 && pnt_o.y_out == '0 && pnt_o.z_out == '0)
    else $error("bad axis beat with nonzero coordinates");

  // a stalled beat at the end of the cordic chain is never dropped
  a_cordic_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[N] && !crdy[N] |=> cv[N])
    else $error("cordic output beat lost during stall");

  // an empty stage ahead of the chain always lets the reducer drain
  a_chain_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cv[1] |-> crdy[0])
    else $error("first cordic stage not ready while empty");

endmodule
